### rtl/core/lbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry package
// Shared widths, register indexes, status codes and beat types of the
// letterbox geometry core.
// ----------------------------------------------------------------------------
package lbg_pkg;

  localparam int DIM_BITS       = 13;
  localparam int GAIN_FRAC_BITS = 16;
  localparam int GAIN_BITS      = DIM_BITS + GAIN_FRAC_BITS;
  localparam int PROD_BITS      = 2 * DIM_BITS;
  localparam int DIV_BITS       = (PROD_BITS > GAIN_BITS) ? PROD_BITS : GAIN_BITS;

  // Divider lanes: scaled width, scaled height and gain share one divisor.
  localparam int DIV_LANES = 3;
  localparam int LANE_W    = 0;
  localparam int LANE_H    = 1;
  localparam int LANE_GAIN = 2;

  localparam int REG_IDX_BITS = 1;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_WIDTH  = 1'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_TARGET_HEIGHT = 1'd1;

  localparam logic [DIM_BITS-1:0] TARGET_RESET = DIM_BITS'(640);

  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_BAD_SOURCE = 2'd1,
    STATUS_BAD_TARGET = 2'd2,
    STATUS_ZERO_SIZE  = 2'd3
  } status_e;

  typedef struct packed {
    logic [DIM_BITS-1:0] source_width;
    logic [DIM_BITS-1:0] source_height;
  } geom_in_t;

  typedef struct packed {
    status_e              status;
    logic [DIM_BITS-1:0]  scaled_width;
    logic [DIM_BITS-1:0]  scaled_height;
    logic [DIM_BITS-1:0]  border_left;
    logic [DIM_BITS-1:0]  border_right;
    logic [DIM_BITS-1:0]  border_top;
    logic [DIM_BITS-1:0]  border_bottom;
    logic [GAIN_BITS-1:0] gain_q16;
  } geom_out_t;

  // Travels alongside the divider so the back end can form pads and status.
  typedef struct packed {
    logic [DIM_BITS-1:0] model_width;
    logic [DIM_BITS-1:0] model_height;
    logic                bad_source;
    logic                bad_target;
  } side_t;

endpackage

### rtl/core/lbg_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry front end
// Registers the beat, forms the four cross products, picks the smaller
// ratio and hands dividends, divisor and sideband to the divider.
// ----------------------------------------------------------------------------
module lbg_front (
  input  logic                                                    clk_i,
  input  logic                                                    rst_ni,
  input  logic                                                    valid_i,
  input  lbg_pkg::geom_in_t                                       geom_i,
  input  logic [lbg_pkg::DIM_BITS-1:0]                            tw_i,
  input  logic [lbg_pkg::DIM_BITS-1:0]                            th_i,
  output logic                                                    valid_o,
  output logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIV_BITS-1:0]    dvd_o,
  output logic [lbg_pkg::DIM_BITS-1:0]                            dvs_o,
  output lbg_pkg::side_t                                          side_o
);

  localparam int DimW  = lbg_pkg::DIM_BITS;
  localparam int ProdW = lbg_pkg::PROD_BITS;
  localparam int DivW  = lbg_pkg::DIV_BITS;

  logic s0_vld_q, s1_vld_q, s2_vld_q;

  logic [DimW-1:0] s0_sw_q, s0_sh_q, s0_tw_q, s0_th_q;

  logic [ProdW-1:0] p_sw_th_q, p_sw_tw_q, p_sh_th_q, p_sh_tw_q;
  logic [DimW-1:0]  s1_sw_q, s1_sh_q, s1_tw_q, s1_th_q;
  logic             s1_bad_src_q, s1_bad_tgt_q;

  logic                                            sel_h;
  logic [DimW-1:0]                                 num;
  logic [lbg_pkg::DIV_LANES-1:0][DivW-1:0]         dvd_d, dvd_q;
  logic [DimW-1:0]                                 dvs_d, dvs_q;
  lbg_pkg::side_t                                  side_d, side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_vld_q <= 1'b0;
      s1_vld_q <= 1'b0;
      s2_vld_q <= 1'b0;
    end else begin
      s0_vld_q <= valid_i;
      s1_vld_q <= s0_vld_q;
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    s0_sw_q <= geom_i.source_width;
    s0_sh_q <= geom_i.source_height;
    s0_tw_q <= tw_i;
    s0_th_q <= th_i;

    p_sw_th_q    <= s0_sw_q * s0_th_q;
    p_sw_tw_q    <= s0_sw_q * s0_tw_q;
    p_sh_th_q    <= s0_sh_q * s0_th_q;
    p_sh_tw_q    <= s0_sh_q * s0_tw_q;
    s1_sw_q      <= s0_sw_q;
    s1_sh_q      <= s0_sh_q;
    s1_tw_q      <= s0_tw_q;
    s1_th_q      <= s0_th_q;
    s1_bad_src_q <= (s0_sw_q == '0) || (s0_sh_q == '0);
    s1_bad_tgt_q <= (s0_tw_q == '0) || (s0_th_q == '0);

    dvd_q  <= dvd_d;
    dvs_q  <= dvs_d;
    side_q <= side_d;
  end

  // The height ratio wins when th/sh <= tw/sw, compared as th*sw <= tw*sh.
  always_comb begin
    sel_h = (p_sw_th_q <= p_sh_tw_q);
    num   = sel_h ? s1_th_q : s1_tw_q;
    dvs_d = sel_h ? s1_sh_q : s1_sw_q;
    dvd_d[lbg_pkg::LANE_W]    = DivW'(sel_h ? p_sw_th_q : p_sw_tw_q);
    dvd_d[lbg_pkg::LANE_H]    = DivW'(sel_h ? p_sh_th_q : p_sh_tw_q);
    dvd_d[lbg_pkg::LANE_GAIN] = DivW'(num) << lbg_pkg::GAIN_FRAC_BITS;
    side_d.model_width  = s1_tw_q;
    side_d.model_height = s1_th_q;
    side_d.bad_source   = s1_bad_src_q;
    side_d.bad_target   = s1_bad_tgt_q;
  end

  assign valid_o = s2_vld_q;
  assign dvd_o   = dvd_q;
  assign dvs_o   = dvs_q;
  assign side_o  = side_q;

endmodule

### rtl/core/lbg_div_pipe.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry divider pipeline
// Restoring division, one quotient bit per stage, over several lanes that
// share one divisor. Gives quotient and remainder after DVD_W stages.
// ----------------------------------------------------------------------------
module lbg_div_pipe #(
  parameter int LANES  = lbg_pkg::DIV_LANES,
  parameter int DVD_W  = lbg_pkg::DIV_BITS,
  parameter int DVS_W  = lbg_pkg::DIM_BITS,
  parameter int SIDE_W = $bits(lbg_pkg::side_t)
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              valid_i,
  input  logic [LANES-1:0][DVD_W-1:0]       dvd_i,
  input  logic [DVS_W-1:0]                  dvs_i,
  input  logic [SIDE_W-1:0]                 side_i,
  output logic                              valid_o,
  output logic [LANES-1:0][DVD_W-1:0]       quo_o,
  output logic [LANES-1:0][DVS_W-1:0]       rem_o,
  output logic [DVS_W-1:0]                  dvs_o,
  output logic [SIDE_W-1:0]                 side_o
);

  // Each stage holds the partial remainder and a shift word that loses a
  // dividend bit at the top and gains a quotient bit at the bottom.
  logic [DVD_W-1:0]                vld_q;
  logic [LANES-1:0][DVD_W-1:0]     dq_q   [DVD_W];
  logic [LANES-1:0][DVS_W-1:0]     rem_q  [DVD_W];
  logic [DVS_W-1:0]                dvs_q  [DVD_W];
  logic [SIDE_W-1:0]               side_q [DVD_W];
  logic [LANES-1:0][DVD_W-1:0]     dq_d   [DVD_W];
  logic [LANES-1:0][DVS_W-1:0]     rem_d  [DVD_W];

  always_comb begin
    logic [DVD_W-1:0] cur_dq;
    logic [DVS_W-1:0] cur_rem;
    logic [DVS_W-1:0] cur_dvs;
    logic [DVS_W:0]   trial;
    logic [DVS_W:0]   diff;
    logic             take;
    for (int k = 0; k < DVD_W; k++) begin
      for (int l = 0; l < LANES; l++) begin
        if (k == 0) begin
          cur_dq  = dvd_i[l];
          cur_rem = '0;
          cur_dvs = dvs_i;
        end else begin
          cur_dq  = dq_q[k-1][l];
          cur_rem = rem_q[k-1][l];
          cur_dvs = dvs_q[k-1];
        end
        trial = {cur_rem, cur_dq[DVD_W-1]};
        diff  = trial - {1'b0, cur_dvs};
        take  = (trial >= {1'b0, cur_dvs});
        rem_d[k][l] = take ? diff[DVS_W-1:0] : trial[DVS_W-1:0];
        dq_d[k][l]  = {cur_dq[DVD_W-2:0], take};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[DVD_W-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < DVD_W; k++) begin
      dq_q[k]  <= dq_d[k];
      rem_q[k] <= rem_d[k];
      if (k == 0) begin
        dvs_q[k]  <= dvs_i;
        side_q[k] <= side_i;
      end else begin
        dvs_q[k]  <= dvs_q[k-1];
        side_q[k] <= side_q[k-1];
      end
    end
  end

  assign valid_o = vld_q[DVD_W-1];
  assign quo_o   = dq_q[DVD_W-1];
  assign rem_o   = rem_q[DVD_W-1];
  assign dvs_o   = dvs_q[DVD_W-1];
  assign side_o  = side_q[DVD_W-1];

endmodule

### rtl/core/lbg_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry back end
// Rounds the scaled size half to even, splits the padding, resolves the
// status and drives the registered result beat.
// ----------------------------------------------------------------------------
module lbg_back (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  valid_i,
  input  logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIV_BITS-1:0]  quo_i,
  input  logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIM_BITS-1:0]  rem_i,
  input  logic [lbg_pkg::DIM_BITS-1:0]                          dvs_i,
  input  lbg_pkg::side_t                                        side_i,
  output logic                                                  done_o,
  output lbg_pkg::geom_out_t                                    result_o
);

  localparam int DimW = lbg_pkg::DIM_BITS;
  localparam int DivW = lbg_pkg::DIV_BITS;

  logic                          r0_vld_q, done_q;
  logic [DivW-1:0]               rnd_w, rnd_h;
  logic [DimW-1:0]               rw_q, rh_q;
  logic                          zero_q;
  logic [lbg_pkg::GAIN_BITS-1:0] gain_q;
  lbg_pkg::side_t                side_q;

  logic [DimW-1:0]               ph, pv;
  lbg_pkg::geom_out_t            result_d, result_q;

  // Round up when the remainder passes half the divisor, or sits exactly on
  // half and the quotient is odd.
  function automatic logic [DivW-1:0] round_even(input logic [DivW-1:0] q,
                                                 input logic [DimW-1:0] r,
                                                 input logic [DimW-1:0] d);
    logic [DimW:0] twice;
    logic [DimW:0] den;
    logic          up;
    twice = {r, 1'b0};
    den   = {1'b0, d};
    up    = (twice > den) || ((twice == den) && q[0]);
    return q + DivW'(up);
  endfunction

  assign rnd_w = round_even(quo_i[lbg_pkg::LANE_W], rem_i[lbg_pkg::LANE_W], dvs_i);
  assign rnd_h = round_even(quo_i[lbg_pkg::LANE_H], rem_i[lbg_pkg::LANE_H], dvs_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r0_vld_q <= 1'b0;
      done_q   <= 1'b0;
    end else begin
      r0_vld_q <= valid_i;
      done_q   <= r0_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    rw_q     <= rnd_w[DimW-1:0];
    rh_q     <= rnd_h[DimW-1:0];
    zero_q   <= (rnd_w == '0) || (rnd_h == '0);
    gain_q   <= quo_i[lbg_pkg::LANE_GAIN][lbg_pkg::GAIN_BITS-1:0];
    side_q   <= side_i;
    result_q <= result_d;
  end

  // The smaller ratio keeps the scaled size within the target, so the
  // subtraction never wraps on a good beat.
  always_comb begin
    ph       = side_q.model_width - rw_q;
    pv       = side_q.model_height - rh_q;
    result_d = '0;
    priority if (side_q.bad_source) begin
      result_d.status = lbg_pkg::STATUS_BAD_SOURCE;
    end else if (side_q.bad_target) begin
      result_d.status = lbg_pkg::STATUS_BAD_TARGET;
    end else if (zero_q) begin
      result_d.status = lbg_pkg::STATUS_ZERO_SIZE;
    end else begin
      result_d.status        = lbg_pkg::STATUS_OK;
      result_d.scaled_width  = rw_q;
      result_d.scaled_height = rh_q;
      result_d.border_left   = ph >> 1;
      result_d.border_right  = (ph >> 1) + DimW'(ph[0]);
      result_d.border_top    = pv >> 1;
      result_d.border_bottom = (pv >> 1) + DimW'(pv[0]);
      result_d.gain_q16      = gain_q;
    end
  end

  assign done_o   = done_q;
  assign result_o = result_q;

endmodule

### rtl/core/letterbox_geometry_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry core
// Computes the letterbox resize size, border pads and gain of a source image
// against the configured model input size.
// ----------------------------------------------------------------------------
// A source size beat is taken on every clock edge where start is high; busy
// is always low because the pipeline takes a new beat in every cycle.
// Exactly one result beat follows each source beat: done_o is high for a
// single cycle per beat and result_o holds the beat in that cycle. Results
// leave in the order taken.
// The divider resolves one quotient bit per stage for the widest dividend;
// three register stages in front form the products and the ratio choice,
// and two behind round and split the pads.
// Target width and height are written through cfg_we_i, cfg_idx_i and
// cfg_wdata_i with no wait, and are meant to change only while no beat is
// in flight. Reset sets both targets to 640 and empties the pipeline; no
// done_o strobe follows reset until a new beat is taken. The receiver
// cannot hold results off, so nothing in the block ever stalls.
// ----------------------------------------------------------------------------
module letterbox_geometry_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  lbg_pkg::geom_in_t                   geom_i,
  input  logic                                cfg_we_i,
  input  logic [lbg_pkg::REG_IDX_BITS-1:0]    cfg_idx_i,
  input  logic [lbg_pkg::DIM_BITS-1:0]        cfg_wdata_i,
  output logic                                done_o,
  output lbg_pkg::geom_out_t                  result_o
);

  localparam int SideW = $bits(lbg_pkg::side_t);

  logic [lbg_pkg::DIM_BITS-1:0] tw_q, th_q;
  logic                         in_valid;

  logic                                                  fe_valid;
  logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIV_BITS-1:0]  fe_dvd;
  logic [lbg_pkg::DIM_BITS-1:0]                          fe_dvs;
  lbg_pkg::side_t                                        fe_side;

  logic                                                  dv_valid;
  logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIV_BITS-1:0]  dv_quo;
  logic [lbg_pkg::DIV_LANES-1:0][lbg_pkg::DIM_BITS-1:0]  dv_rem;
  logic [lbg_pkg::DIM_BITS-1:0]                          dv_dvs;
  logic [SideW-1:0]                                      fe_side_vec, dv_side_vec;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_q <= lbg_pkg::TARGET_RESET;
      th_q <= lbg_pkg::TARGET_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        lbg_pkg::REG_TARGET_WIDTH:  tw_q <= cfg_wdata_i;
        lbg_pkg::REG_TARGET_HEIGHT: th_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy     = 1'b0;
  assign in_valid = start && !busy;

  lbg_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid),
    .geom_i  (geom_i),
    .tw_i    (tw_q),
    .th_i    (th_q),
    .valid_o (fe_valid),
    .dvd_o   (fe_dvd),
    .dvs_o   (fe_dvs),
    .side_o  (fe_side)
  );

  assign fe_side_vec = fe_side;

  lbg_div_pipe #(
    .LANES  (lbg_pkg::DIV_LANES),
    .DVD_W  (lbg_pkg::DIV_BITS),
    .DVS_W  (lbg_pkg::DIM_BITS),
    .SIDE_W (SideW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fe_valid),
    .dvd_i   (fe_dvd),
    .dvs_i   (fe_dvs),
    .side_i  (fe_side_vec),
    .valid_o (dv_valid),
    .quo_o   (dv_quo),
    .rem_o   (dv_rem),
    .dvs_o   (dv_dvs),
    .side_o  (dv_side_vec)
  );

  lbg_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (dv_valid),
    .quo_i    (dv_quo),
    .rem_i    (dv_rem),
    .dvs_i    (dv_dvs),
    .side_i   (lbg_pkg::side_t'(dv_side_vec)),
    .done_o   (done_o),
    .result_o (result_o)
  );

endmodule

### tb/letterbox_geometry_core_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Letterbox geometry core testbench
// Drives source size beats in random bursts against a series of target
// sizes, predicts scaled size, pads, gain and status for every beat, and
// checks each result beat field by field in arrival order.
// ----------------------------------------------------------------------------
module letterbox_geometry_core_tb;

  import lbg_pkg::*;

  localparam int LATENCY       = DIV_BITS + 5;
  localparam int STALL_LIMIT   = 4000;
  localparam int RANDOM_PHASES = 11;
  localparam int PHASE_ITEMS   = 52;
  localparam int REPORT_LIMIT  = 10;
  localparam logic [DIM_BITS-1:0] DIM_MAX = {DIM_BITS{1'b1}};

  class geometry_scoreboard;
    longint unsigned target_w;
    longint unsigned target_h;
    geom_out_t       pending_geoms[$];
    int              mismatches;
    int              results_checked;
    int              target_writes;
    int              status_hits[4];

    function new();
      target_w = TARGET_RESET;
      target_h = TARGET_RESET;
    endfunction

    function void write_target(logic [REG_IDX_BITS-1:0] idx, logic [DIM_BITS-1:0] val);
      target_writes++;
      if (idx == REG_TARGET_WIDTH) target_w = val;
      else if (idx == REG_TARGET_HEIGHT) target_h = val;
    endfunction

    // value * num / den, rounded half to even with an exact remainder.
    function longint unsigned round_half_even(longint unsigned value, longint unsigned num,
                                              longint unsigned den);
      longint unsigned prod, quo, rem;
      prod = value * num;
      quo  = prod / den;
      rem  = prod % den;
      if (2 * rem > den || (2 * rem == den && quo[0])) quo++;
      return quo;
    endfunction

    function geom_out_t predict_letterbox(geom_in_t src);
      longint unsigned sw, sh, num, den, rw, rh, ph, pv;
      geom_out_t r;
      r  = '0;
      sw = src.source_width;
      sh = src.source_height;
      if (sw == 0 || sh == 0) begin
        r.status = STATUS_BAD_SOURCE;
      end else if (target_w == 0 || target_h == 0) begin
        r.status = STATUS_BAD_TARGET;
      end else begin
        // The height ratio wins ties; both ratios are equal then anyway.
        if (target_h * sw <= target_w * sh) begin
          num = target_h;
          den = sh;
        end else begin
          num = target_w;
          den = sw;
        end
        rw = round_half_even(sw, num, den);
        rh = round_half_even(sh, num, den);
        if (rw == 0 || rh == 0) begin
          r.status = STATUS_ZERO_SIZE;
        end else begin
          ph = target_w - rw;
          pv = target_h - rh;
          r.status        = STATUS_OK;
          r.scaled_width  = DIM_BITS'(rw);
          r.scaled_height = DIM_BITS'(rh);
          r.border_left   = DIM_BITS'(ph >> 1);
          r.border_right  = DIM_BITS'(ph - (ph >> 1));
          r.border_top    = DIM_BITS'(pv >> 1);
          r.border_bottom = DIM_BITS'(pv - (pv >> 1));
          r.gain_q16      = GAIN_BITS'((num << GAIN_FRAC_BITS) / den);
        end
      end
      return r;
    endfunction

    function void note_source(geom_in_t src);
      pending_geoms.push_back(predict_letterbox(src));
    endfunction

    function string show(geom_out_t g);
      return $sformatf("st=%0d w=%0d h=%0d l=%0d r=%0d t=%0d b=%0d gain=%0d",
                       g.status, g.scaled_width, g.scaled_height, g.border_left,
                       g.border_right, g.border_top, g.border_bottom, g.gain_q16);
    endfunction

    function void check_result(geom_out_t got);
      geom_out_t want;
      if (pending_geoms.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("ERROR %0t: result beat with no source beat pending: %s", $time, show(got));
        return;
      end
      want = pending_geoms.pop_front();
      results_checked++;
      status_hits[want.status]++;
      if (got.status !== want.status || got.scaled_width !== want.scaled_width ||
          got.scaled_height !== want.scaled_height || got.border_left !== want.border_left ||
          got.border_right !== want.border_right || got.border_top !== want.border_top ||
          got.border_bottom !== want.border_bottom || got.gain_q16 !== want.gain_q16) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("ERROR %0t: result beat mismatch", $time);
          $display("  expected %s", show(want));
          $display("  actual   %s", show(got));
        end
      end
    endfunction
  endclass

  logic                    clk_i       = 1'b0;
  logic                    rst_ni      = 1'b0;
  logic                    start       = 1'b0;
  logic                    busy;
  geom_in_t                geom_i      = '0;
  logic                    cfg_we_i    = 1'b0;
  logic [REG_IDX_BITS-1:0] cfg_idx_i   = REG_TARGET_WIDTH;
  logic [DIM_BITS-1:0]     cfg_wdata_i = '0;
  logic                    done_o;
  geom_out_t               result_o;

  geometry_scoreboard sb;
  geom_in_t           source_q[$];
  int                 sources_taken;
  int                 quiet_cycles;
  int                 failures;

  letterbox_geometry_core dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .geom_i      (geom_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .done_o      (done_o),
    .result_o    (result_o)
  );

  always #6 clk_i = ~clk_i;

  // Monitor: sampled values at the edge are the ones the block sees.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (cfg_we_i) sb.write_target(cfg_idx_i, cfg_wdata_i);
      if (start && !busy) begin
        sb.note_source(geom_i);
        sources_taken++;
      end
      if (done_o) sb.check_result(result_o);
      if ((start && !busy) || done_o) quiet_cycles = 0;
      else quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("ERROR: no beat moved for %0d cycles, %0d results still pending",
                 STALL_LIMIT, sb.pending_geoms.size());
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  function automatic geom_in_t dims(int w, int h);
    geom_in_t s;
    s.source_width  = DIM_BITS'(w);
    s.source_height = DIM_BITS'(h);
    return s;
  endfunction

  function automatic logic [DIM_BITS-1:0] pick_target();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 8) return '0;
    if (roll < 33) return DIM_BITS'($urandom_range(1, 64));
    if (roll < 38) return DIM_MAX;
    return DIM_BITS'($urandom_range(1, DIM_MAX));
  endfunction

  function automatic geom_in_t pick_source();
    geom_in_t s;
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 60) begin
      s = dims($urandom_range(1, DIM_MAX), $urandom_range(1, DIM_MAX));
    end else if (roll < 75) begin
      s = dims($urandom_range(1, 64), $urandom_range(1, 64));
    end else if (roll < 85) begin
      // Very thin images, where one side tends to round away to nothing.
      s = dims($urandom_range(1, 8), $urandom_range(1024, DIM_MAX));
      if ($urandom_range(0, 1)) s = {s.source_height, s.source_width};
    end else if (roll < 92) begin
      s = dims($urandom_range(0, DIM_MAX), $urandom_range(0, DIM_MAX));
      case ($urandom_range(0, 2))
        0: s.source_width = '0;
        1: s.source_height = '0;
        default: s = '0;
      endcase
    end else begin
      s = $bits(geom_in_t)'($urandom);
    end
    return s;
  endfunction

  // Sends the queued source beats in bursts with random gaps between them.
  task automatic play_sources();
    int burst;
    int gap;
    while (source_q.size() > 0) begin
      burst = $urandom_range(1, 24);
      while (burst > 0 && source_q.size() > 0) begin
        start  <= 1'b1;
        geom_i <= source_q.pop_front();
        @(posedge clk_i);
        while (busy) @(posedge clk_i);
        burst--;
      end
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
      if (gap > 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    start <= 1'b0;
  endtask

  task automatic wait_drained();
    while (sb.pending_geoms.size() != 0) @(posedge clk_i);
    repeat (LATENCY) @(posedge clk_i);
  endtask

  task automatic set_targets(logic [DIM_BITS-1:0] w, logic [DIM_BITS-1:0] h);
    wait_drained();
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= REG_TARGET_WIDTH;
    cfg_wdata_i <= w;
    @(posedge clk_i);
    cfg_idx_i   <= REG_TARGET_HEIGHT;
    cfg_wdata_i <= h;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Targets as they come out of reset (640 x 640).
    source_q = '{dims(0, 0), dims(0, 8191), dims(8191, 0), dims(1, 1), dims(8191, 8191),
                 dims(640, 640), dims(1280, 1280), dims(1280, 5), dims(1280, 7),
                 dims(1280, 1), dims(8191, 1), dims(1, 8191), dims(1920, 1080)};
    play_sources();

    // A zero target; a zero source must still win.
    set_targets('0, 13'd640);
    source_q = '{dims(1920, 1080), dims(0, 1080)};
    play_sources();
    set_targets(13'd640, '0);
    source_q = '{dims(1, 1), dims(1080, 1920)};
    play_sources();

    set_targets(DIM_MAX, DIM_MAX);
    source_q = '{dims(8191, 8191), dims(1, 1), dims(8191, 1)};
    play_sources();
    set_targets(13'd1, 13'd1);
    source_q = '{dims(8191, 8191), dims(2, 1), dims(1, 1)};
    play_sources();

    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      case (phase)
        0: set_targets(DIM_MAX, 13'd1);
        1: set_targets(13'd1, DIM_MAX);
        2: set_targets(13'd416, 13'd256);
        default: set_targets(pick_target(), pick_target());
      endcase
      repeat (PHASE_ITEMS) source_q.push_back(pick_source());
      play_sources();
    end

    wait_drained();
    repeat (LATENCY) @(posedge clk_i);
    failures = sb.mismatches + sb.pending_geoms.size();
    $display("Summary: %0d source beats, %0d results checked, %0d target writes.",
             sources_taken, sb.results_checked, sb.target_writes);
    $display("Status mix: ok %0d, bad source %0d, bad target %0d, zero size %0d; %0d failures.",
             sb.status_hits[STATUS_OK], sb.status_hits[STATUS_BAD_SOURCE],
             sb.status_hits[STATUS_BAD_TARGET], sb.status_hits[STATUS_ZERO_SIZE], failures);
    if (failures == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

### files.f
rtl/core/lbg_pkg.sv
rtl/core/lbg_front.sv
rtl/core/lbg_div_pipe.sv
rtl/core/lbg_back.sv
rtl/core/letterbox_geometry_core.sv
tb/letterbox_geometry_core_tb.sv
